// File: rtl/core/kvrsp_pkg.sv
// types, codes and helpers shared by the record stream parser
// no dependencies; imported by every module of the parser
package kvrsp_pkg;

    // bytes in each little-endian length field
    localparam int unsigned LEN_BYTES = 4;

    typedef enum logic [2:0] {
        PH_KLEN = 3'd0,
        PH_KEY  = 3'd1,
        PH_TAG  = 3'd2,
        PH_VLEN = 3'd3,
        PH_VAL  = 3'd4
    } t_phase;

    typedef logic [2:0] t_role;
    localparam t_role ROLE_KLEN = 3'd0;
    localparam t_role ROLE_KEY  = 3'd1;
    localparam t_role ROLE_TAG  = 3'd2;
    localparam t_role ROLE_VLEN = 3'd3;
    localparam t_role ROLE_VAL  = 3'd4;
    localparam t_role ROLE_NONE = 3'd5;

    typedef logic [2:0] t_status;
    localparam t_status STAT_OK        = 3'd0;
    localparam t_status STAT_KLEN_CUT  = 3'd1;
    localparam t_status STAT_KEY_CUT   = 3'd2;
    localparam t_status STAT_TAG_CUT   = 3'd3;
    localparam t_status STAT_VLEN_CUT  = 3'd4;
    localparam t_status STAT_VAL_CUT   = 3'd5;
    localparam t_status STAT_TOMB_VAL  = 3'd6;
    localparam t_status STAT_BAD_TAG   = 3'd7;

    // register index within the apb map
    localparam logic REG_DATA_TAG = 1'b0;
    localparam logic REG_TOMB_TAG = 1'b1;

    typedef struct packed {
        logic [7:0] data_tag;
        logic [7:0] tomb_tag;
    } t_tag_cfg;

    // per-word flags from the parse core
    typedef struct packed {
        logic [7:0] byte_out;
        t_role      role;
        logic       done;
        logic       tomb;
        t_status    status;
    } t_step_flags;

    function automatic t_role phase_role(input t_phase ph);
        t_role r;
        unique case (ph)
            PH_KLEN: r = ROLE_KLEN;
            PH_KEY:  r = ROLE_KEY;
            PH_TAG:  r = ROLE_TAG;
            PH_VLEN: r = ROLE_VLEN;
            PH_VAL:  r = ROLE_VAL;
            default: r = ROLE_NONE;
        endcase
        return r;
    endfunction

    function automatic t_status cut_status(input t_phase ph);
        t_status s;
        unique case (ph)
            PH_KLEN: s = STAT_KLEN_CUT;
            PH_KEY:  s = STAT_KEY_CUT;
            PH_TAG:  s = STAT_TAG_CUT;
            PH_VLEN: s = STAT_VLEN_CUT;
            PH_VAL:  s = STAT_VAL_CUT;
            default: s = STAT_KLEN_CUT;
        endcase
        return s;
    endfunction

    // places a byte at its little-endian lane
    function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] idx);
        logic [31:0] w;
        unique case (idx)
            2'd0:    w = {24'd0, b};
            2'd1:    w = {16'd0, b, 8'd0};
            2'd2:    w = {8'd0, b, 16'd0};
            default: w = {b, 24'd0};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/kvrsp_cfg_regs.sv
// apb register file holding the data and tombstone tag codes
// depends on kvrsp_pkg
module kvrsp_cfg_regs
    import kvrsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_tag_cfg    o_cfg
);

    logic [7:0] r_data_tag;
    logic [7:0] r_tomb_tag;
    logic       w_wr;
    logic       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    // byte offset bits are ignored
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_tag <= 8'd0;
            r_tomb_tag <= 8'd1;
        end else if (w_wr) begin
            if (w_idx == REG_DATA_TAG) begin
                r_data_tag <= pwdata[7:0];
            end else begin
                r_tomb_tag <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DATA_TAG: prdata = {24'd0, r_data_tag};
            default:      prdata = {24'd0, r_tomb_tag};
        endcase
    end

    assign o_cfg.data_tag = r_data_tag;
    assign o_cfg.tomb_tag = r_tomb_tag;

endmodule

// File: rtl/core/kvrsp_parse_core.sv
// parse state and the single-pass per-byte update
// depends on kvrsp_pkg; driven from the registered input word
module kvrsp_parse_core
    import kvrsp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_command,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_in_block,
    input  t_tag_cfg               i_cfg,
    output t_step_flags            o_flags,
    output logic [LENGTH_BITS-1:0] o_key_len,
    output logic [LENGTH_BITS-1:0] o_value_len
);

    localparam logic [LENGTH_BITS-1:0] REM_FULL = LENGTH_BITS'(LEN_BYTES);
    localparam logic [LENGTH_BITS-1:0] REM_ONE  = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;

    t_phase                  r_phase,     n_phase;
    logic [LENGTH_BITS-1:0]  r_remaining, n_remaining;
    logic [LENGTH_BITS-1:0]  r_key_len,   n_key_len;
    logic [LENGTH_BITS-1:0]  r_val_len,   n_val_len;
    logic [7:0]              r_tag,       n_tag;
    t_status                 r_error,     n_error;

    logic                    w_finish;
    logic [LENGTH_BITS-1:0]  w_rem_norm;
    logic [LENGTH_BITS-1:0]  w_rem_dec;
    logic [LENGTH_BITS-1:0]  w_cnt_dec;
    logic [1:0]              w_idx;
    logic [31:0]             w_placed_full;
    logic [LENGTH_BITS-1:0]  w_placed;
    logic                    w_klen_first;
    logic                    w_is_data;
    logic                    w_is_tomb;

    // length-field counter wraps back to a full field where needed
    assign w_klen_first = (r_phase == PH_KLEN) && (r_remaining >= REM_FULL);
    assign w_rem_norm   = (w_klen_first ||
                           ((r_phase == PH_VLEN) &&
                            ((r_remaining > REM_FULL) || (r_remaining == LEN_ZERO))))
                          ? REM_FULL : r_remaining;
    assign w_rem_dec     = w_rem_norm - REM_ONE;
    assign w_cnt_dec     = (r_remaining != LEN_ZERO) ? (r_remaining - REM_ONE) : LEN_ZERO;
    assign w_idx         = 2'(3'(LEN_BYTES) - w_rem_norm[2:0]);
    assign w_placed_full = place_byte(i_data_byte, w_idx);
    assign w_placed      = w_placed_full[LENGTH_BITS-1:0];
    assign w_is_data     = (r_tag == i_cfg.data_tag);
    assign w_is_tomb     = (r_tag == i_cfg.tomb_tag);

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_key_len   = r_key_len;
        n_val_len   = r_val_len;
        n_tag       = r_tag;
        n_error     = r_error;
        w_finish    = 1'b0;
        if (i_command) begin
            n_phase     = PH_KLEN;
            n_remaining = REM_FULL;
            n_key_len   = LEN_ZERO;
            n_val_len   = LEN_ZERO;
            n_tag       = 8'd0;
            n_error     = STAT_OK;
        end else if (r_error == STAT_OK) begin
            unique case (r_phase)
                PH_KLEN: begin
                    n_key_len   = (w_klen_first ? LEN_ZERO : r_key_len) | w_placed;
                    n_val_len   = w_klen_first ? LEN_ZERO : r_val_len;
                    n_remaining = w_rem_dec;
                    if (w_rem_dec == LEN_ZERO) begin
                        if (n_key_len == LEN_ZERO) begin
                            n_phase     = PH_TAG;
                            n_remaining = REM_ONE;
                        end else begin
                            n_phase     = PH_KEY;
                            n_remaining = n_key_len;
                        end
                    end
                end
                PH_KEY: begin
                    n_remaining = w_cnt_dec;
                    if (w_cnt_dec == LEN_ZERO) begin
                        n_phase     = PH_TAG;
                        n_remaining = REM_ONE;
                    end
                end
                PH_TAG: begin
                    n_tag       = i_data_byte;
                    n_phase     = PH_VLEN;
                    n_remaining = REM_FULL;
                    n_val_len   = LEN_ZERO;
                end
                PH_VLEN: begin
                    n_val_len   = r_val_len | w_placed;
                    n_remaining = w_rem_dec;
                    if (w_rem_dec == LEN_ZERO) begin
                        if (n_val_len == LEN_ZERO) begin
                            w_finish = 1'b1;
                        end else begin
                            n_phase     = PH_VAL;
                            n_remaining = n_val_len;
                        end
                    end
                end
                PH_VAL: begin
                    n_remaining = w_cnt_dec;
                    w_finish    = (w_cnt_dec == LEN_ZERO);
                end
                default: begin
                    n_phase     = PH_KLEN;
                    n_remaining = REM_FULL;
                end
            endcase

            if (w_finish) begin
                // data code wins when both tag codes match
                if (!w_is_data) begin
                    if (w_is_tomb) begin
                        if (n_val_len != LEN_ZERO) begin
                            n_error = STAT_TOMB_VAL;
                        end
                    end else begin
                        n_error = STAT_BAD_TAG;
                    end
                end
                n_phase     = PH_KLEN;
                n_remaining = REM_FULL;
            end

            // block ended away from a record boundary
            if (i_last_in_block && (n_error == STAT_OK) &&
                !((n_phase == PH_KLEN) && (n_remaining == REM_FULL))) begin
                n_error = cut_status(n_phase);
            end
        end
    end

    // outputs
    always_comb begin
        o_flags.byte_out = i_command ? 8'd0 : i_data_byte;
        o_flags.role     = (i_command || (r_error != STAT_OK)) ? ROLE_NONE
                                                               : phase_role(r_phase);
        o_flags.done     = w_finish && (w_is_data || (w_is_tomb && (n_val_len == LEN_ZERO)));
        o_flags.tomb     = w_finish && !w_is_data && w_is_tomb && (n_val_len == LEN_ZERO);
        o_flags.status   = n_error;
        o_key_len        = n_key_len;
        o_value_len      = n_val_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_KLEN;
            r_remaining <= REM_FULL;
            r_key_len   <= LEN_ZERO;
            r_val_len   <= LEN_ZERO;
            r_tag       <= 8'd0;
            r_error     <= STAT_OK;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_key_len   <= n_key_len;
            r_val_len   <= n_val_len;
            r_tag       <= n_tag;
            r_error     <= n_error;
        end
    end

endmodule

// File: rtl/core/kv_record_stream_parser.sv
// top level of the key/value record stream parser: input and result registers
// depends on kvrsp_pkg, kvrsp_cfg_regs and kvrsp_parse_core
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | i_valid / o_stall   | i_command, i_data_byte, i_last_in_block
//  result   | o_valid / i_stall   | o_byte_out, o_byte_role, o_record_done,
//           |                     | o_is_tombstone, o_key_len_out,
//           |                     | o_value_len_out, o_status
//  config   | apb psel/penable    | paddr, pwdata, prdata, pready
//
// one word per cycle while i_stall is low; a word passes the input register, then the
// result register, from which its result is shown on the result channel
// the parse state updates as a word moves from the input to the result register
// synchronous active-low reset; no clearing pass, the block takes words at once
// a stalled result holds, and one more word can wait in the input register
module kv_record_stream_parser
    import kvrsp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_command,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_in_block,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_byte_out,
    output logic [2:0]             o_byte_role,
    output logic                   o_record_done,
    output logic                   o_is_tombstone,
    output logic [LENGTH_BITS-1:0] o_key_len_out,
    output logic [LENGTH_BITS-1:0] o_value_len_out,
    output logic [2:0]             o_status
);

    t_tag_cfg               w_cfg;
    t_step_flags            w_flags;
    logic [LENGTH_BITS-1:0] w_key_len;
    logic [LENGTH_BITS-1:0] w_val_len;

    logic                   r_in_valid;
    logic                   r_in_cmd;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;

    logic                   r_out_valid;
    t_step_flags            r_out_flags;
    logic [LENGTH_BITS-1:0] r_out_key_len;
    logic [LENGTH_BITS-1:0] r_out_val_len;

    logic                   w_out_free;
    logic                   w_in_free;
    logic                   w_step;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_in_free  = !r_in_valid || w_out_free;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = !w_in_free;

    kvrsp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kvrsp_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_command       (r_in_cmd),
        .i_data_byte     (r_in_byte),
        .i_last_in_block (r_in_last),
        .i_cfg           (w_cfg),
        .o_flags         (w_flags),
        .o_key_len       (w_key_len),
        .o_value_len     (w_val_len)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_valid) begin
            r_in_cmd  <= i_command;
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_in_block;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_flags   <= w_flags;
            r_out_key_len <= w_key_len;
            r_out_val_len <= w_val_len;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_out      = r_out_flags.byte_out;
    assign o_byte_role     = r_out_flags.role;
    assign o_record_done   = r_out_flags.done;
    assign o_is_tombstone  = r_out_flags.tomb;
    assign o_status        = r_out_flags.status;
    assign o_key_len_out   = r_out_key_len;
    assign o_value_len_out = r_out_val_len;

endmodule

// File: test/kv_record_stream_parser_tb.sv
// self-checking testbench for kv_record_stream_parser: drives record streams with random
// gaps and stalls, predicts every echoed word and compares it on the result channel
// depends on kvrsp_pkg and the parser rtl
`timescale 1ns / 1ps

module kv_record_stream_parser_tb;
    import kvrsp_pkg::*;

    localparam int LEN_W = 32;
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic [7:0]       byte_out;
        t_role            role;
        logic             done;
        logic             tomb;
        logic [LEN_W-1:0] key_len;
        logic [LEN_W-1:0] val_len;
        t_status          status;
    } t_kv_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_valid;
    logic             o_stall;
    logic             i_command;
    logic [7:0]       i_data_byte;
    logic             i_last_in_block;
    logic             o_valid;
    logic             i_stall;
    logic [7:0]       o_byte_out;
    logic [2:0]       o_byte_role;
    logic             o_record_done;
    logic             o_is_tombstone;
    logic [LEN_W-1:0] o_key_len_out;
    logic [LEN_W-1:0] o_value_len_out;
    logic [2:0]       o_status;

    // parser state as the predictor sees it
    t_phase      phase;
    logic [31:0] bytes_left;
    logic [31:0] key_len_q;
    logic [31:0] val_len_q;
    logic [7:0]  tag_q;
    t_status     err_q;
    logic [7:0]  cfg_data_tag;
    logic [7:0]  cfg_tomb_tag;

    t_kv_result predicted_words[$];
    int         words_sent;
    int         fail_count;
    int         records_seen;
    int         tombstones_seen;
    int         sticky_words;
    int         tag_settings;
    logic [7:0] status_seen;
    bit         no_idle;

    kv_record_stream_parser #(
        .LENGTH_BITS(LEN_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_data_byte    (i_data_byte),
        .i_last_in_block(i_last_in_block),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_out     (o_byte_out),
        .o_byte_role    (o_byte_role),
        .o_record_done  (o_record_done),
        .o_is_tombstone (o_is_tombstone),
        .o_key_len_out  (o_key_len_out),
        .o_value_len_out(o_value_len_out),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d words still expected", predicted_words.size());
        $display("kv_record_stream_parser_tb NOT OK");
        $finish;
    end

    // switches between idling and back-to-back stretches
    initial begin
        no_idle = 1'b0;
        forever begin
            repeat ($urandom_range(40, 160)) @(posedge i_clk);
            no_idle = ($urandom_range(0, 3) == 0);
        end
    end

    function automatic void clear_parser();
        phase      = PH_KLEN;
        bytes_left = LEN_BYTES;
        key_len_q  = '0;
        val_len_q  = '0;
        tag_q      = '0;
        err_q      = STAT_OK;
    endfunction

    function automatic t_kv_result parse_word(input logic cmd, input logic [7:0] b,
                                              input logic last);
        t_kv_result r;
        logic       finish;
        logic [1:0] lane;
        r.byte_out = b;
        r.role     = ROLE_NONE;
        r.done     = 1'b0;
        r.tomb     = 1'b0;
        finish     = 1'b0;
        if (cmd == CMD_RESTART) begin
            clear_parser();
            r.byte_out = 8'd0;
        end else if (err_q == STAT_OK) begin
            case (phase)
                PH_KLEN: begin
                    r.role = ROLE_KLEN;
                    if (bytes_left >= LEN_BYTES) begin
                        bytes_left = LEN_BYTES;
                        key_len_q  = '0;
                        val_len_q  = '0;
                    end
                    lane       = 2'(LEN_BYTES - bytes_left);
                    key_len_q  = key_len_q | (32'(b) << (8 * lane));
                    bytes_left = bytes_left - 1;
                    if (bytes_left == 0) begin
                        if (key_len_q == 0) begin
                            phase      = PH_TAG;
                            bytes_left = 1;
                        end else begin
                            phase      = PH_KEY;
                            bytes_left = key_len_q;
                        end
                    end
                end
                PH_KEY: begin
                    r.role = ROLE_KEY;
                    if (bytes_left > 0) bytes_left = bytes_left - 1;
                    if (bytes_left == 0) begin
                        phase      = PH_TAG;
                        bytes_left = 1;
                    end
                end
                PH_TAG: begin
                    r.role     = ROLE_TAG;
                    tag_q      = b;
                    phase      = PH_VLEN;
                    bytes_left = LEN_BYTES;
                    val_len_q  = '0;
                end
                PH_VLEN: begin
                    r.role = ROLE_VLEN;
                    if (bytes_left > LEN_BYTES || bytes_left == 0) bytes_left = LEN_BYTES;
                    lane       = 2'(LEN_BYTES - bytes_left);
                    val_len_q  = val_len_q | (32'(b) << (8 * lane));
                    bytes_left = bytes_left - 1;
                    if (bytes_left == 0) begin
                        if (val_len_q == 0) begin
                            finish = 1'b1;
                        end else begin
                            phase      = PH_VAL;
                            bytes_left = val_len_q;
                        end
                    end
                end
                PH_VAL: begin
                    r.role = ROLE_VAL;
                    if (bytes_left > 0) bytes_left = bytes_left - 1;
                    if (bytes_left == 0) finish = 1'b1;
                end
                default: begin
                    phase      = PH_KLEN;
                    bytes_left = LEN_BYTES;
                end
            endcase

            // data code wins when both registers hold the same tag
            if (finish) begin
                if (tag_q == cfg_data_tag) begin
                    r.done = 1'b1;
                end else if (tag_q == cfg_tomb_tag) begin
                    if (val_len_q != 0) begin
                        err_q = STAT_TOMB_VAL;
                    end else begin
                        r.done = 1'b1;
                        r.tomb = 1'b1;
                    end
                end else begin
                    err_q = STAT_BAD_TAG;
                end
                phase      = PH_KLEN;
                bytes_left = LEN_BYTES;
            end

            if (last && err_q == STAT_OK && !(phase == PH_KLEN && bytes_left == LEN_BYTES))
                err_q = t_status'(3'(phase) + 3'd1);
        end
        r.key_len = key_len_q;
        r.val_len = val_len_q;
        r.status  = err_q;
        return r;
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    task automatic check_word(input t_kv_result got);
        t_kv_result want;
        if (predicted_words.size() == 0) begin
            report_failure($sformatf("%0t: word with nothing expected: byte %h role %0d status %0d",
                                     $time, got.byte_out, got.role, got.status));
            return;
        end
        want = predicted_words.pop_front();
        if (got !== want)
            report_failure($sformatf({"%0t: mismatch (expected/actual) byte %h/%h role %0d/%0d ",
                                      "done %b/%b tomb %b/%b klen %h/%h vlen %h/%h status %0d/%0d"},
                                     $time, want.byte_out, got.byte_out, want.role, got.role,
                                     want.done, got.done, want.tomb, got.tomb,
                                     want.key_len, got.key_len, want.val_len, got.val_len,
                                     want.status, got.status));
        if (got.done) records_seen++;
        if (got.done && got.tomb) tombstones_seen++;
        if (got.role == ROLE_NONE && got.status != STAT_OK) sticky_words++;
        status_seen[got.status] = 1'b1;
    endtask

    // result side: random stall before each word, sampled mid-cycle
    initial begin : result_sink
        t_kv_result got;
        int         hold;
        bit         taken;
        i_stall <= 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            taken = 1'b0;
            while (!taken) begin
                @(negedge i_clk);
                taken = o_valid;
                got   = {o_byte_out, o_byte_role, o_record_done, o_is_tombstone,
                         o_key_len_out, o_value_len_out, o_status};
                @(posedge i_clk);
            end
            check_word(got);
        end
    end

    task automatic send_word(input logic cmd, input logic [7:0] value, input logic last);
        int gap;
        bit taken;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_data_byte     <= value;
        i_last_in_block <= last;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        predicted_words.push_back(parse_word(cmd, value, last));
        words_sent++;
    endtask

    task automatic send_restart();
        send_word(CMD_RESTART, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input logic close_block);
        foreach (seq[i])
            send_word(CMD_BYTE, seq[i], close_block && (i == seq.size() - 1));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus goes idle before the next transfer
        @(posedge i_clk);
        if (idx == REG_DATA_TAG) cfg_data_tag = value;
        else cfg_tomb_tag = value;
    endtask

    task automatic set_tag_codes(input logic [7:0] data_code, input logic [7:0] tomb_code);
        wait_idle();
        write_reg(REG_DATA_TAG, data_code);
        write_reg(REG_TOMB_TAG, tomb_code);
        tag_settings++;
    endtask

    // one record with random lengths and tag; may end the block early or be cut by a restart
    task automatic send_record();
        logic [31:0] key_len;
        logic [31:0] val_len;
        logic [7:0]  tag;
        logic [7:0]  seq[$];
        int          pick;
        int          cut_at;
        int          restart_at;
        logic        close_block;
        pick    = $urandom_range(0, 99);
        key_len = pick < 20 ? 0 : (pick < 95 ? $urandom_range(1, 6) : $urandom_range(7, 40));
        pick    = $urandom_range(0, 99);
        tag     = pick < 45 ? cfg_data_tag : (pick < 80 ? cfg_tomb_tag : 8'($urandom));
        pick    = $urandom_range(0, 99);
        if (tag == cfg_tomb_tag) val_len = pick < 85 ? 0 : $urandom_range(1, 3);
        else val_len = pick < 20 ? 0 : $urandom_range(1, 6);
        for (int i = 0; i < 4; i++) seq.push_back(key_len[8*i +: 8]);
        repeat (key_len) seq.push_back(8'($urandom));
        seq.push_back(tag);
        for (int i = 0; i < 4; i++) seq.push_back(val_len[8*i +: 8]);
        repeat (val_len) seq.push_back(8'($urandom));
        cut_at      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, seq.size() - 2) : -1;
        restart_at  = ($urandom_range(0, 24) == 0) ? $urandom_range(0, seq.size() - 1) : -1;
        close_block = ($urandom_range(0, 3) == 0);
        foreach (seq[i]) begin
            if (i == restart_at) begin
                send_restart();
                return;
            end
            send_word(CMD_BYTE, seq[i], (i == cut_at) || (close_block && i == seq.size() - 1));
            if (i == cut_at) return;
        end
    endtask

    task automatic test_directed_records();
        // deletion with empty key and value, block closes on a record boundary
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
        // unknown tag reported on the last value byte, which also ends the block
        send_bytes('{8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00,
                     8'h00}, 1'b1);
        // error holds until restart
        send_word(CMD_BYTE, 8'hFF, 1'b1);
        send_word(CMD_RESTART, 8'hFF, 1'b1);
        // block ends inside the key length
        send_word(CMD_BYTE, 8'hFF, 1'b1);
        send_word(CMD_RESTART, 8'h00, 1'b0);
    endtask

    task automatic test_random_records(input int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words) begin
            if ($urandom_range(0, 99) < 6) begin
                repeat ($urandom_range(1, 6))
                    send_word($urandom_range(0, 5) == 0, 8'($urandom), $urandom_range(0, 3) == 0);
                send_restart();
            end else begin
                send_record();
                if (err_q != STAT_OK) begin
                    repeat ($urandom_range(0, 2)) send_word(CMD_BYTE, 8'($urandom), 1'($urandom));
                    send_restart();
                end else if ($urandom_range(0, 7) == 0) begin
                    send_restart();
                end
            end
        end
    endtask

    task automatic test_shared_tag_code();
        set_tag_codes(8'h5A, 8'h5A);
        // same code in both registers: the record with a value counts as data
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h02, 8'h00, 8'h00, 8'h00,
                     8'h3C, 8'hC3}, 1'b1);
        test_random_records(150);
    endtask

    initial begin : run
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_command       <= CMD_BYTE;
        i_data_byte     <= 8'd0;
        i_last_in_block <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        words_sent      = 0;
        fail_count      = 0;
        records_seen    = 0;
        tombstones_seen = 0;
        sticky_words    = 0;
        tag_settings    = 1;
        status_seen     = '0;
        cfg_data_tag    = 8'd0;
        cfg_tomb_tag    = 8'd1;
        clear_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_records();
        test_random_records(240);
        set_tag_codes(8'hFF, 8'h00);
        test_random_records(200);
        test_shared_tag_code();
        set_tag_codes(8'($urandom), 8'($urandom));
        test_random_records(170);
        set_tag_codes(8'h00, 8'hFF);
        test_random_records(150);
        wait_idle();

        $display("sent %0d words under %0d tag settings: %0d records done, %0d deletions",
                 words_sent, tag_settings, records_seen, tombstones_seen);
        $display("%0d of 8 status codes seen, %0d words echoed while an error was held",
                 $countones(status_seen), sticky_words);
        if (fail_count == 0) begin
            $display("kv_record_stream_parser_tb OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("kv_record_stream_parser_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/kvrsp_pkg.sv
rtl/core/kvrsp_cfg_regs.sv
rtl/core/kvrsp_parse_core.sv
rtl/core/kv_record_stream_parser.sv
test/kv_record_stream_parser_tb.sv
